// File: src/multiturn_encoder_gear_unwrap_assert.svh
// Assertion macros shared by the encoder unwrap RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MULTITURN_ENCODER_GEAR_UNWRAP_ASSERT_SVH
`define MULTITURN_ENCODER_GEAR_UNWRAP_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is high.
`define MTGU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MTGU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MTGU_ASSERT(label, clk, rst, prop, msg)
`define MTGU_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: src/mtgu_pkg.sv
// Package for the multi-turn encoder unwrap: widths, register indexes,
// reset values, sequencer states and the divider status group. No dependencies.
package mtgu_pkg;

  localparam int ANGLE_W   = 13;
  localparam int THR_W     = 13;
  localparam int RATIO_W   = 10;
  localparam int POS_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam int COUNTS_PER_TURN_DEF = 8192;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_WRAP_THRESHOLD = cfg_idx_t'(0);
  localparam cfg_idx_t REG_GEAR_RATIO     = cfg_idx_t'(1);
  localparam cfg_idx_t REG_HALVING_MODE   = cfg_idx_t'(2);

  localparam logic [THR_W-1:0]   WRAP_THRESHOLD_RST = THR_W'(4096);
  localparam logic [RATIO_W-1:0] GEAR_RATIO_RST     = RATIO_W'(36);

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(32767);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_ADJ,
    ST_SUM_GO,
    ST_SUM_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/mtgu_ifs.sv
// Valid/ready channel interfaces for the encoder unwrap: sample input,
// position output and configuration write. Depends on mtgu_pkg.
interface mtgu_sample_if;
  logic                          valid;
  logic                          ready;
  logic [mtgu_pkg::ANGLE_W-1:0]  angle;
  logic                          started;

  modport source (output valid, angle, started, input ready);
  modport sink   (input valid, angle, started, output ready);
endinterface

interface mtgu_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [mtgu_pkg::POS_W-1:0] position;

  modport source (output valid, position, input ready);
  modport sink   (input valid, position, output ready);
endinterface

interface mtgu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mtgu_pkg::CFG_IDX_W-1:0] index;
  logic [mtgu_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/mtgu_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mtgu_pkg and the assertion macro header.
`include "multiturn_encoder_gear_unwrap_assert.svh"

module mtgu_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    numer,
  input  logic [DEN_W-1:0]    denom,
  output logic [NUM_W-1:0]    quot,
  output logic [DEN_W-1:0]    remd,
  output mtgu_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             borrow;

  always_comb begin
    trial  = {rem, quo[NUM_W-1]};
    diff   = {1'b0, trial} - {2'b00, den};
    borrow = diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift in one numerator bit, keep the trial subtract when it does not borrow
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ~borrow};
      rem <= borrow ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
    end
  end

  assign quot      = quo;
  assign remd      = rem;
  assign stat.busy = busy;
  assign stat.done = done;

  `MTGU_ASSERT(a_no_restart, clk, rst, start |-> !busy, "divider started while busy")
  `MTGU_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "done without a run")
  `MTGU_ASSERT(a_rem_below_den, clk, rst, done |-> (rem < den), "remainder not reduced")

endmodule

// File: src/multiturn_encoder_gear_unwrap.sv
// Top level of the multi-turn encoder unwrap with gear reduction.
// Depends on mtgu_pkg, mtgu_ifs (channels), mtgu_div and the assertion header.
//
//   port     dir   carries                         transfer when
//   sample   sink  angle[12:0], started            sample.valid && sample.ready
//   result   src   position[15:0] signed           result.valid && result.ready
//   cfg      sink  index[1:0], data[12:0]          cfg.valid && cfg.ready
//
// SUM_W is 23 at 8192 counts per turn.
// One shared restoring divider reduces the turn count modulo the ratio on a
// wrap and then divides the unwrapped sum, one bit a cycle; halving mode
// skips the divide and halves the sum instead.
// A new sample is taken while the previous position still waits in the output
// register; a stalled result holds the sequencer only at its last step.
// Reset is synchronous and needs no clearing pass; cfg is always ready.
`include "multiturn_encoder_gear_unwrap_assert.svh"

module multiturn_encoder_gear_unwrap #(
  parameter int COUNTS_PER_TURN = mtgu_pkg::COUNTS_PER_TURN_DEF
) (
  input  logic clk,
  input  logic rst,
  mtgu_sample_if.sink   sample,
  mtgu_result_if.source result,
  mtgu_cfg_if.sink      cfg
);

  localparam int ANGLE_W = mtgu_pkg::ANGLE_W;
  localparam int RATIO_W = mtgu_pkg::RATIO_W;
  localparam int POS_W   = mtgu_pkg::POS_W;
  // widest unwrapped sum: top angle plus the largest turn count
  localparam int SUM_W = $clog2(COUNTS_PER_TURN * (2**RATIO_W - 1) + 2**ANGLE_W);
  localparam logic [SUM_W-1:0] CPT = SUM_W'(COUNTS_PER_TURN);

  // configuration registers
  logic [mtgu_pkg::THR_W-1:0] wrap_threshold;
  logic [RATIO_W-1:0]         gear_ratio;
  logic                       halving_mode;

  // block state
  logic [ANGLE_W-1:0] last_angle;
  logic [RATIO_W-1:0] turn_count;

  // per-sample working registers
  logic [ANGLE_W-1:0] angle;
  logic               started;
  logic               wrap_up;
  logic [POS_W-1:0]   res;
  logic               out_valid;
  logic [POS_W-1:0]   out_pos;

  mtgu_pkg::state_t state, state_next;

  // divider hookup
  logic                div_start;
  logic [SUM_W-1:0]    div_numer;
  logic [SUM_W-1:0]    div_quot;
  logic [RATIO_W-1:0]  div_remd;
  mtgu_pkg::div_stat_t div_stat;

  logic [RATIO_W-1:0] ratio;
  logic [SUM_W-1:0]   sum;
  logic [ANGLE_W:0]   lo_bound;
  logic [ANGLE_W:0]   hi_bound;
  logic               drop;
  logic               rise;
  logic               take;
  logic               out_free;
  logic [RATIO_W-1:0] t_inc;
  logic [RATIO_W-1:0] t_dec;

  always_comb begin
    ratio = (gear_ratio == '0) ? RATIO_W'(1) : gear_ratio;
  end

  // wrap detect against the previous reading, at the sample transfer
  always_comb begin
    lo_bound = {1'b0, sample.angle} + {1'b0, wrap_threshold};
    hi_bound = {1'b0, last_angle} + {1'b0, wrap_threshold};
    drop     = sample.started && ({1'b0, last_angle} > lo_bound);
    rise     = sample.started && ({1'b0, sample.angle} > hi_bound);
  end

  always_comb begin
    sum = started ? (SUM_W'(angle) + CPT * SUM_W'(turn_count)) : SUM_W'(angle);
  end

  // step the reduced count up or down, modulo the ratio
  always_comb begin
    t_inc = (div_remd + RATIO_W'(1) == ratio) ? '0 : div_remd + RATIO_W'(1);
    t_dec = (div_remd == '0) ? ratio - RATIO_W'(1) : div_remd - RATIO_W'(1);
  end

  assign sample.ready = (state == mtgu_pkg::ST_IDLE);
  assign take         = sample.valid && sample.ready;
  assign out_free     = !out_valid || result.ready;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtgu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_numer  = sum;
    unique case (state)
      mtgu_pkg::ST_IDLE: begin
        if (take) begin
          state_next = (drop || rise) ? mtgu_pkg::ST_MOD_GO : mtgu_pkg::ST_SUM_GO;
        end
      end
      mtgu_pkg::ST_MOD_GO: begin
        div_start  = 1'b1;
        div_numer  = SUM_W'(turn_count);
        state_next = mtgu_pkg::ST_MOD_WAIT;
      end
      mtgu_pkg::ST_MOD_WAIT: begin
        if (div_stat.done) begin
          state_next = mtgu_pkg::ST_ADJ;
        end
      end
      mtgu_pkg::ST_ADJ: begin
        state_next = mtgu_pkg::ST_SUM_GO;
      end
      mtgu_pkg::ST_SUM_GO: begin
        // halving skips the divider
        if (halving_mode) begin
          state_next = mtgu_pkg::ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = mtgu_pkg::ST_SUM_WAIT;
        end
      end
      mtgu_pkg::ST_SUM_WAIT: begin
        if (div_stat.done) begin
          state_next = mtgu_pkg::ST_FINISH;
        end
      end
      mtgu_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = mtgu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtgu_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_threshold <= mtgu_pkg::WRAP_THRESHOLD_RST;
      gear_ratio     <= mtgu_pkg::GEAR_RATIO_RST;
      halving_mode   <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        mtgu_pkg::REG_WRAP_THRESHOLD: wrap_threshold <= cfg.data[mtgu_pkg::THR_W-1:0];
        mtgu_pkg::REG_GEAR_RATIO:     gear_ratio     <= cfg.data[RATIO_W-1:0];
        mtgu_pkg::REG_HALVING_MODE:   halving_mode   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // block state: last reading and turn count
  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle <= '0;
      turn_count <= '0;
    end else begin
      if (take) begin
        last_angle <= sample.angle;
      end
      if (state == mtgu_pkg::ST_ADJ) begin
        turn_count <= wrap_up ? t_inc : t_dec;
      end
    end
  end

  // latch the sample, then capture the saturated quotient or halved sum
  always_ff @(posedge clk) begin
    if (take) begin
      angle   <= sample.angle;
      started <= sample.started;
      wrap_up <= drop;
    end
    if (state == mtgu_pkg::ST_SUM_GO && halving_mode) begin
      res <= ((sum >> 1) > SUM_W'(mtgu_pkg::POS_MAX)) ? mtgu_pkg::POS_MAX
                                                      : POS_W'(sum >> 1);
    end else if (state == mtgu_pkg::ST_SUM_WAIT && div_stat.done) begin
      res <= (div_quot > SUM_W'(mtgu_pkg::POS_MAX)) ? mtgu_pkg::POS_MAX
                                                    : div_quot[POS_W-1:0];
    end
  end

  // output register: load at the last step, drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mtgu_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mtgu_pkg::ST_FINISH && out_free) begin
      out_pos <= res;
    end
  end

  assign result.valid    = out_valid;
  assign result.position = out_pos;

  mtgu_div #(
    .NUM_W (SUM_W),
    .DEN_W (RATIO_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (ratio),
    .quot  (div_quot),
    .remd  (div_remd),
    .stat  (div_stat)
  );

  `MTGU_ASSERT(a_count_moves_in_adj, clk, rst, !$stable(turn_count) |-> $past(state) == mtgu_pkg::ST_ADJ, "turn count changed outside the adjust step")
  `MTGU_ASSERT(a_valid_from_finish, clk, rst, $rose(out_valid) |-> $past(state) == mtgu_pkg::ST_FINISH, "result raised outside the finish step")
  `MTGU_ASSERT(a_adj_reduced, clk, rst, (state == mtgu_pkg::ST_ADJ) |-> (div_remd < ratio), "reduced count not below the ratio")

endmodule
